[rtl/ssra_pkg.sv]
// ----------------------------------------------------------------------------
// ssra_pkg
// Shared types and codes for the segmented stack with indexed removal.
// ----------------------------------------------------------------------------
package ssra_pkg;

    // Request kinds
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_POP_AT = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Fixed field widths and constants
    localparam int          DATA_W    = 32;
    localparam int          CAP_W     = 7;
    localparam int          IDX_W     = 6;
    localparam int          PROD_W    = CAP_W + IDX_W;
    localparam logic [6:0]  CAP_RESET = 7'd10;
    localparam logic [31:0] NEG_ONE   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic [5:0]         sub_sel;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic [1:0]         status;
        logic [6:0]         count_after;
    } rsp_t;

endpackage

[rtl/ssra_cell.sv]
// ----------------------------------------------------------------------------
// ssra_cell
// One storage cell of the chain: loads a pushed value, copies its upper
// neighbor when a removal at or below it closes the gap, and offers its
// value for readout when it is the selected position.
// ----------------------------------------------------------------------------
module ssra_cell
    import ssra_pkg::*;
#(
    parameter int AW    = 6,
    parameter int INDEX = 0
)
(
    input  logic              clk,
    input  logic              write_en,
    input  logic              shift_en,
    input  logic [AW-1:0]     pos,
    input  logic [DATA_W-1:0] wdata,
    input  logic [DATA_W-1:0] up_data,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] rd_data
);

    localparam logic [AW-1:0] MY_POS = AW'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              hit;

    assign hit = (pos == MY_POS);

    // Load on push, close the gap on removal
    always_comb
    begin
        data_next = data_reg;
        if (write_en && hit)
        begin
            data_next = wdata;
        end
        else if (shift_en && (MY_POS >= pos))
        begin
            data_next = up_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // Masked readout, OR-combined by the row
    assign rd_data = hit ? data_reg : '0;

endmodule

[rtl/ssra_cell_row.sv]
// ----------------------------------------------------------------------------
// ssra_cell_row
// Row of DEPTH cells, each linked to its upper neighbor, plus the OR
// combine of the selected cell's value.
// ----------------------------------------------------------------------------
module ssra_cell_row
    import ssra_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic              clk,
    input  logic              write_en,
    input  logic              shift_en,
    input  logic [AW-1:0]     pos,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] cell_data   [DEPTH];
    logic [DATA_W-1:0] cell_masked [DEPTH];

    // Cell chain; the top cell keeps its own value on a shift
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] up;
        if (i == DEPTH - 1)
        begin : g_top
            assign up = cell_data[i];
        end
        else
        begin : g_mid
            assign up = cell_data[i+1];
        end

        ssra_cell #(
            .AW    (AW),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .write_en (write_en),
            .shift_en (shift_en),
            .pos      (pos),
            .wdata    (wdata),
            .up_data  (up),
            .data     (cell_data[i]),
            .rd_data  (cell_masked[i])
        );
    end

    // At most one cell is selected
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_data = rd_data | cell_masked[i];
        end
    end

endmodule

[rtl/segmented_stack_with_remove_at_core.sv]
// ----------------------------------------------------------------------------
// segmented_stack_with_remove_at_core
// Segmented stack of DEPTH 32-bit entries with push, pop and removal from
// the top of a chosen substack.
// ----------------------------------------------------------------------------
// A request is registered in S_IDLE and executed in S_EXEC; no new request
// is accepted before execution ends. The split comes from the registered
// index-times-capacity product that execution needs. In S_EXEC every cell at
// or above the removed position copies its upper neighbor at once, so a
// removal with shift costs no extra time. Execution waits while the previous
// result is held in the output register and stalled; a new request is
// accepted while that result waits. No clearing pass runs after reset. A
// stack_capacity of 0 acts as 1.
module segmented_stack_with_remove_at_core
    import ssra_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = ((CW > PROD_W) ? CW : PROD_W) + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    logic [0:0]        state_reg,   state_next;
    logic [CW-1:0]     count_reg,   count_next;
    logic [CAP_W-1:0]  cap_reg;
    req_t              req_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg,     rsp_next;

    logic              req_fire;
    logic              exec_fire;
    logic [CAP_W-1:0]  cap;
    logic              write_en;
    logic              shift_en;
    logic              do_read;
    logic [AW-1:0]     pos;
    logic [DATA_W-1:0] rd_data;
    logic [1:0]        status;
    logic [WW-1:0]     cnt_w;
    logic [WW-1:0]     top_w;

    assign cap       = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign exec_fire = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // Request capture with the substack base product
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg  <= req;
            prod_reg <= PROD_W'(req.sub_sel) * PROD_W'(cap);
        end
    end

    // Execute decode
    assign cnt_w = WW'(count_reg);
    assign top_w = WW'(prod_reg) + WW'(cap) - WW'(1);

    always_comb
    begin
        write_en   = 1'b0;
        shift_en   = 1'b0;
        do_read    = 1'b0;
        pos        = '0;
        status     = ST_INVALID;
        count_next = count_reg;
        case (req_reg.kind)
            KIND_PUSH:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status     = ST_OK;
                    write_en   = 1'b1;
                    pos        = count_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_POP:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    status     = ST_OK;
                    shift_en   = 1'b1;
                    do_read    = 1'b1;
                    pos        = AW'(count_reg - CW'(1));
                    count_next = count_reg - CW'(1);
                end
            end
            KIND_POP_AT:
            begin
                // Index valid only when its base lies below the count
                if (WW'(prod_reg) < cnt_w)
                begin
                    status     = ST_OK;
                    shift_en   = 1'b1;
                    do_read    = 1'b1;
                    pos        = (top_w < cnt_w) ? top_w[AW-1:0]
                                                 : AW'(cnt_w - WW'(1));
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                status = ST_INVALID;
            end
        endcase
    end

    ssra_cell_row #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_row (
        .clk      (clk),
        .write_en (write_en && exec_fire),
        .shift_en (shift_en && exec_fire),
        .pos      (pos),
        .wdata    (req_reg.value),
        .rd_data  (rd_data)
    );

    // Result assembly
    always_comb
    begin
        rsp_next.value_res   = do_read ? rd_data : NEG_ONE;
        rsp_next.status      = status;
        rsp_next.count_after = CAP_W'(count_next);
    end

    // Control state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req_fire)  state_next = S_EXEC;
            S_EXEC:  if (exec_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above depth");

    a_req_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_EXEC))
        else $error("accepted request not executed next");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> rsp_valid)
        else $error("executed request produced no result");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_fire |=> $stable(count_reg))
        else $error("entry count changed outside execute");

    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(write_en && shift_en))
        else $error("push and shift in the same cycle");

endmodule
